@@ hw/rtl/ffcc_pkg.sv @@
// ----------------------------------------------------------------------------
// ffcc_pkg: shared types and constants for the fan and compressor controller
// Widths of the temperature, threshold and tick fields, the register indexes
// of the configuration port and the status bundle passed between modules.
// ----------------------------------------------------------------------------
package ffcc_pkg;

    // Field widths.
    localparam int TEMP_W     = 12;
    localparam int DEV_W      = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Probe arrangement. PROBE_COUNT must be a power of two no larger than
    // INPUT_FIELDS, so that the mean is an arithmetic shift.
    localparam int INPUT_FIELDS = 4;
    localparam int PROBE_COUNT  = 4;
    localparam int DIV_SHIFT    = $clog2(PROBE_COUNT);
    localparam int SUM_W        = TEMP_W + DIV_SHIFT;
    localparam int DIFF_W       = TEMP_W + 1;

    // Reset values of the configuration registers.
    localparam int SET_TEMP_RESET = 64;
    localparam int ON_DEV_RESET   = 16;
    localparam int OFF_DEV_RESET  = 8;
    localparam int MIN_OFF_RESET  = 75;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [DEV_W-1:0]         dev_t;
    typedef logic [TICK_W-1:0]        tick_t;
    typedef temp_t                    probe_arr_t [INPUT_FIELDS];

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_TEMP = 2'd0,
        REG_ON_DEV   = 2'd1,
        REG_OFF_DEV  = 2'd2,
        REG_MIN_OFF  = 2'd3
    } cfg_index_t;

    // Result of the averaging and spread check for one transaction.
    typedef struct packed {
        temp_t avg;
        logic  any_far;
        logic  all_near;
    } stats_t;

endpackage

@@ hw/rtl/ffcc_if.sv @@
// ----------------------------------------------------------------------------
// ffcc_if: valid/ready channels of the fan and compressor controller
// The probe channel carries one control tick; the drive channel carries the
// fan and compressor commands with the averaged temperature.
// ----------------------------------------------------------------------------
interface ffcc_probe_if;
    import ffcc_pkg::*;

    logic  valid;
    logic  ready;
    temp_t probe_temp_0;
    temp_t probe_temp_1;
    temp_t probe_temp_2;
    temp_t probe_temp_3;

    modport source (
        output valid,
        output probe_temp_0,
        output probe_temp_1,
        output probe_temp_2,
        output probe_temp_3,
        input  ready
    );

    modport sink (
        input  valid,
        input  probe_temp_0,
        input  probe_temp_1,
        input  probe_temp_2,
        input  probe_temp_3,
        output ready
    );
endinterface

interface ffcc_drive_if;
    import ffcc_pkg::*;

    logic  valid;
    logic  ready;
    logic  fan_drive;
    logic  compressor_drive;
    temp_t average_temp;

    modport source (
        output valid,
        output fan_drive,
        output compressor_drive,
        output average_temp,
        input  ready
    );

    modport sink (
        input  valid,
        input  fan_drive,
        input  compressor_drive,
        input  average_temp,
        output ready
    );
endinterface

@@ hw/rtl/ffcc_stats.sv @@
// ----------------------------------------------------------------------------
// ffcc_stats: probe average and spread check
// Truncating mean of the probes, then the exact deviation of each probe from
// it, compared against the fan on and off thresholds.
// ----------------------------------------------------------------------------
module ffcc_stats (
    input  ffcc_pkg::probe_arr_t probes,
    input  ffcc_pkg::dev_t       fan_on_dev,
    input  ffcc_pkg::dev_t       fan_off_dev,
    output ffcc_pkg::stats_t     stats
);
    import ffcc_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] biased;
    temp_t                   avg;

    // Sum of the probes; a negative sum is biased so the shift truncates
    // towards zero like a signed division.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            sum = sum + SUM_W'(probes[i]);
        end
        bias   = sum[SUM_W-1] ? SUM_W'(PROBE_COUNT - 1) : '0;
        biased = sum + bias;
        avg    = TEMP_W'(biased >>> DIV_SHIFT);
    end

    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        stats.avg      = avg;
        stats.any_far  = 1'b0;
        stats.all_near = 1'b1;
        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            diff = DIFF_W'(probes[i]) - DIFF_W'(avg);
            mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            if (mag > DIFF_W'(fan_on_dev))
            begin
                stats.any_far = 1'b1;
            end
            if (mag > DIFF_W'(fan_off_dev))
            begin
                stats.all_near = 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/ffcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffcc_ctrl: fan and compressor state with minimum off time
// Holds the fan and compressor states and the saturating off-time counter,
// and updates them once per transaction that leaves the input stage.
// ----------------------------------------------------------------------------
module ffcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  ffcc_pkg::stats_t stats,
    input  ffcc_pkg::temp_t  set_temp,
    input  ffcc_pkg::tick_t  min_off,
    output logic             fan_next,
    output logic             comp_next
);
    import ffcc_pkg::*;

    logic  fan_reg;
    logic  comp_reg;
    tick_t ticks_reg;
    tick_t ticks_next;
    tick_t ticks_inc;
    logic  start_ok;

    always_comb
    begin
        ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
        start_ok  = (stats.avg > set_temp) && (ticks_inc >= min_off);

        if (stats.any_far)
        begin
            fan_next = 1'b1;
        end
        else if (stats.all_near)
        begin
            fan_next = 1'b0;
        end
        else
        begin
            fan_next = fan_reg;
        end

        comp_next  = comp_reg;
        ticks_next = ticks_inc;
        if (start_ok)
        begin
            comp_next = 1'b1;
        end
        else if (stats.avg < set_temp)
        begin
            comp_next  = 1'b0;
            ticks_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_reg   <= 1'b0;
            comp_reg  <= 1'b0;
            ticks_reg <= '0;
        end
        else if (advance)
        begin
            fan_reg   <= fan_next;
            comp_reg  <= comp_next;
            ticks_reg <= ticks_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The compressor only starts when warm and after the minimum off time.
    a_start_guard : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(comp_reg) |-> $past(start_ok && advance))
        else $error("compressor started without off-time guard");

    // Switching the compressor off always restarts the off-time count.
    a_off_clears : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(comp_reg) |-> (ticks_reg == '0))
        else $error("off-time counter not cleared on compressor stop");

    // State only moves when a transaction is processed.
    a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(fan_reg) && $stable(comp_reg) && $stable(ticks_reg))
        else $error("controller state changed without a transaction");
`endif

endmodule

@@ hw/rtl/fridge_fan_compressor_control_unit.sv @@
// ----------------------------------------------------------------------------
// fridge_fan_compressor_control_unit: refrigerator fan and compressor control
// Thermostat with a probe-spread fan rule and a minimum compressor off time.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the probe channel is one control tick carrying four
// signed probe temperatures in 1/16 degree units. For every tick the block
// returns one transaction on the drive channel with the fan command, the
// compressor command and the truncated mean of the probes.
// The block is a two-stage pipeline: an input register holding the probes,
// then the averaging, spread check and thermostat logic feeding an output
// register. A result is offered on the drive channel from the output
// register once its tick has left the input register. A new tick can be
// accepted every cycle while the receiver takes results, so the sustained
// rate is one tick per cycle; the fan, compressor and off-time counter
// states are updated once per tick.
// When the receiver stalls, the output register holds its result and the
// input register keeps the next tick; the probe channel drops ready only
// once both are full, so nothing is lost or repeated.
// Reset clears the fan and compressor states and the off-time counter and
// loads the default set point and thresholds. The configuration port is a
// plain write port and should only be written while the block is idle.
// ----------------------------------------------------------------------------
module fridge_fan_compressor_control_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    ffcc_probe_if.sink                          probe,
    ffcc_drive_if.source                        drive,
    input  logic                                cfg_we,
    input  ffcc_pkg::cfg_index_t                cfg_index,
    input  logic [ffcc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ffcc_pkg::*;

    // Configuration registers.
    temp_t set_temp_reg;
    dev_t  on_dev_reg;
    dev_t  off_dev_reg;
    tick_t min_off_reg;

    // Input stage.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    probe_arr_t probe_reg;

    // Output stage.
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  fan_out_reg;
    logic  comp_out_reg;
    temp_t avg_out_reg;

    logic   accept;
    logic   advance;
    stats_t stats;
    logic   fan_next;
    logic   comp_next;

    // The input stage moves on whenever the output register is empty or is
    // being emptied in this cycle.
    assign advance     = s1_valid_reg && (!out_valid_reg || drive.ready);
    assign probe.ready = !s1_valid_reg || advance;
    assign accept      = probe.valid && probe.ready;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (drive.ready ? 1'b0 : out_valid_reg);

    // Configuration writes; the register index covers exactly the four
    // registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_temp_reg <= TEMP_W'(SET_TEMP_RESET);
            on_dev_reg   <= DEV_W'(ON_DEV_RESET);
            off_dev_reg  <= DEV_W'(OFF_DEV_RESET);
            min_off_reg  <= TICK_W'(MIN_OFF_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_TEMP: set_temp_reg <= temp_t'(cfg_wdata[TEMP_W-1:0]);
                REG_ON_DEV:   on_dev_reg   <= cfg_wdata[DEV_W-1:0];
                REG_OFF_DEV:  off_dev_reg  <= cfg_wdata[DEV_W-1:0];
                REG_MIN_OFF:  min_off_reg  <= cfg_wdata[TICK_W-1:0];
                default:      ;
            endcase
        end
    end

    // Handshake state of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            probe_reg[0] <= probe.probe_temp_0;
            probe_reg[1] <= probe.probe_temp_1;
            probe_reg[2] <= probe.probe_temp_2;
            probe_reg[3] <= probe.probe_temp_3;
        end
        if (advance)
        begin
            fan_out_reg  <= fan_next;
            comp_out_reg <= comp_next;
            avg_out_reg  <= stats.avg;
        end
    end

    ffcc_stats u_stats (
        .probes      (probe_reg),
        .fan_on_dev  (on_dev_reg),
        .fan_off_dev (off_dev_reg),
        .stats       (stats)
    );

    ffcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .stats     (stats),
        .set_temp  (set_temp_reg),
        .min_off   (min_off_reg),
        .fan_next  (fan_next),
        .comp_next (comp_next)
    );

    assign drive.valid            = out_valid_reg;
    assign drive.fan_drive        = fan_out_reg;
    assign drive.compressor_drive = comp_out_reg;
    assign drive.average_temp     = avg_out_reg;

endmodule

@@ dv/fridge_fan_compressor_control_unit_tb.sv @@
// ----------------------------------------------------------------------------
// fridge_fan_compressor_control_unit_tb: self-checking bench for the fridge
// fan and compressor controller
// A directed table covers the field extremes, the truncating mean, the fan
// hysteresis and the compressor off-time rules. Random phases follow under
// several register settings, including a gap-free run at the largest minimum
// off time. A predictor checks every drive transaction field by
// field, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module fridge_fan_compressor_control_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffcc_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 2_000_000;
    // Quiet cycles allowed once every result has been taken, before the
    // registers are touched or the run ends.
    localparam int SETTLE_CYCLES    = 4;
    localparam int RANDOM_PHASES    = 7;
    localparam int PHASE_TICKS      = 170;
    localparam int SATURATION_PHASE = 3;
    localparam int SATURATION_TICKS = 170;
    localparam int IDLE_PERCENT     = 28;
    localparam int DIRECTED_STEPS   = 25;

    // Row kinds and whether a row's expected result is typed into the table.
    localparam logic TICK  = 1'b0;
    localparam logic WRITE = 1'b1;
    localparam logic CHK   = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic  fan;
        logic  comp;
        temp_t avg;
    } drive_result_t;

    typedef struct packed {
        logic                  is_write;
        cfg_index_t            idx;
        logic [CFG_DATA_W-1:0] wdata;
        temp_t                 p0;
        temp_t                 p1;
        temp_t                 p2;
        temp_t                 p3;
        logic                  check;
        logic                  fan;
        logic                  comp;
        temp_t                 avg;
    } step_t;

    // Bias of the random temperatures relative to the set point, held for a
    // segment of ticks so that the compressor can sit out its off time.
    typedef enum int {
        TREND_WARM,
        TREND_COOL,
        TREND_STEADY
    } trend_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ffcc_probe_if probe_ch ();
    ffcc_drive_if drive_ch ();

    // Expected result pinned by the directed table; it travels with the tick
    // on the probe channel so that the scoreboard sees it at acceptance.
    logic          fixed_check;
    drive_result_t fixed_result;
    bit            sender_steady;

    // Controller state and registers as the bench believes them to be.
    temp_t set_point    = temp_t'(SET_TEMP_RESET);
    dev_t  on_margin    = dev_t'(ON_DEV_RESET);
    dev_t  off_margin   = dev_t'(OFF_DEV_RESET);
    tick_t min_off_time = tick_t'(MIN_OFF_RESET);
    logic  fan_on       = 1'b0;
    logic  comp_on      = 1'b0;
    tick_t off_time     = '0;

    drive_result_t expected_drives [$];
    int            ticks_in_flight = 0;
    int            fail_count      = 0;
    int            cycle_count     = 0;
    trend_t        trend           = TREND_STEADY;
    int            segment_left    = 0;

    // Extremes of the probe fields, the truncation of a negative mean, the fan
    // hysteresis, an on threshold below the off threshold, a zero and a
    // maximal minimum off time, and register writes with junk in the spare
    // upper bits.
    step_t directed_steps [DIRECTED_STEPS] = '{
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          CHK, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd2000, 12'sd2000, 12'sd2000, 12'sd2000,
          CHK, 1'b0, 1'b0, 12'sd2000},
        '{TICK,  REG_SET_TEMP, 16'h0000, -12'sd800, -12'sd800, -12'sd800, -12'sd800,
          CHK, 1'b0, 1'b0, -12'sd800},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047,
          CHK, 1'b0, 1'b0, 12'sd2047},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sh800, 12'sh800, 12'sh800, 12'sh800,
          CHK, 1'b0, 1'b0, 12'sh800},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd2047, 12'sh800, 12'sd2047, 12'sh800,
          CHK, 1'b1, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, -12'sd1, -12'sd1, -12'sd1, 12'sd0,
          CHK, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, -12'sd5, -12'sd5, -12'sd5, -12'sd6,
          CHK, 1'b0, 1'b0, -12'sd5},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd100, 12'sd100, 12'sd100, 12'sd120,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd100, 12'sd100, 12'sd100, 12'sd140,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd100, 12'sd100, 12'sd100, 12'sd120,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd100, 12'sd100, 12'sd100, 12'sd104,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{WRITE, REG_ON_DEV,   16'h5A04, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{WRITE, REG_OFF_DEV,  16'hC314, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{WRITE, REG_MIN_OFF,  16'h0000, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{WRITE, REG_SET_TEMP, 16'hA064, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd100, 12'sd100, 12'sd100, 12'sd100,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd101, 12'sd101, 12'sd101, 12'sd101,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd100, 12'sd100, 12'sd100, 12'sd100,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd99, 12'sd99, 12'sd99, 12'sd99,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd90, 12'sd90, 12'sd90, 12'sd100,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{WRITE, REG_SET_TEMP, 16'h0CE0, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{WRITE, REG_MIN_OFF,  16'hFFFF, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, -12'sd799, -12'sd799, -12'sd799, -12'sd799,
          PRED, 1'b0, 1'b0, 12'sd0},
        '{TICK,  REG_SET_TEMP, 16'h0000, 12'sd2000, -12'sd800, 12'sd2000, -12'sd800,
          PRED, 1'b0, 1'b0, 12'sd0}
    };

    fridge_fan_compressor_control_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe     (probe_ch),
        .drive     (drive_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Advances the bench's copy of the controller by one control tick and
    // returns the drive transaction that the tick should produce. The mean
    // truncates towards zero, so a slightly negative sum gives zero.
    function automatic drive_result_t thermostat_tick(input probe_arr_t p);
        int            sum;
        int            avg;
        int            dev;
        logic          far;
        logic          near;
        drive_result_t r;
        sum  = 0;
        far  = 1'b0;
        near = 1'b1;
        if (off_time != '1)
            off_time++;
        for (int k = 0; k < PROBE_COUNT; k++)
            sum += int'(p[k]);
        avg = sum / PROBE_COUNT;
        for (int k = 0; k < PROBE_COUNT; k++)
        begin
            dev = int'(p[k]) - avg;
            if (dev < 0)
                dev = -dev;
            if (dev > int'(on_margin))
                far = 1'b1;
            if (dev > int'(off_margin))
                near = 1'b0;
        end
        if (far)
            fan_on = 1'b1;
        else if (near)
            fan_on = 1'b0;
        if (avg > int'(set_point))
        begin
            if (off_time >= min_off_time)
                comp_on = 1'b1;
        end
        else if (avg < int'(set_point))
        begin
            comp_on  = 1'b0;
            off_time = '0;
        end
        r.fan  = fan_on;
        r.comp = comp_on;
        r.avg  = temp_t'(avg);
        return r;
    endfunction

    function automatic temp_t clamp_temp(input int v);
        if (v > 2047)
            v = 2047;
        else if (v < -2048)
            v = -2048;
        return temp_t'(v);
    endfunction

    // Everything is sampled at the rising edge, before the block's own
    // registers and the bench's nonblocking drives have settled, so the
    // values seen are those that the edge itself acted upon.
    always @(posedge clk)
    begin : scoreboard
        drive_result_t want;
        probe_arr_t    taken;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SET_TEMP: set_point    = cfg_wdata[TEMP_W-1:0];
                    REG_ON_DEV:   on_margin    = cfg_wdata[DEV_W-1:0];
                    REG_OFF_DEV:  off_margin   = cfg_wdata[DEV_W-1:0];
                    REG_MIN_OFF:  min_off_time = cfg_wdata[TICK_W-1:0];
                    default:      ;
                endcase
            end
            if (probe_ch.valid && probe_ch.ready)
            begin
                taken[0] = probe_ch.probe_temp_0;
                taken[1] = probe_ch.probe_temp_1;
                taken[2] = probe_ch.probe_temp_2;
                taken[3] = probe_ch.probe_temp_3;
                want = thermostat_tick(taken);
                // A typed-in table result replaces the prediction, but the
                // predictor still steps so that its state stays in line.
                if (fixed_check)
                    want = fixed_result;
                expected_drives.push_back(want);
            end
            if (drive_ch.valid && drive_ch.ready)
            begin
                if (expected_drives.size() == 0)
                begin
                    $error("drive transaction with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (drive_ch.fan_drive !== want.fan)
                    begin
                        $error("fan_drive: expected %0d, got %0d",
                               want.fan, drive_ch.fan_drive);
                        fail_count++;
                    end
                    if (drive_ch.compressor_drive !== want.comp)
                    begin
                        $error("compressor_drive: expected %0d, got %0d",
                               want.comp, drive_ch.compressor_drive);
                        fail_count++;
                    end
                    if (drive_ch.average_temp !== want.avg)
                    begin
                        $error("average_temp: expected %0d, got %0d",
                               want.avg, drive_ch.average_temp);
                        fail_count++;
                    end
                end
            end
            ticks_in_flight <= expected_drives.size();
        end
    end

    // Receiver on the drive channel. It mostly takes results with random
    // gaps, sometimes runs for a long stretch without any, and now and then
    // holds off for a long stretch. The first long hold is placed while the
    // sender is busy, so that both pipeline stages fill and the probe
    // channel has to drop ready.
    initial
    begin : receiver
        int stall_left;
        int steady_left;
        bit forced_done;
        int pick;
        stall_left     = 0;
        steady_left    = 0;
        forced_done    = 1'b0;
        drive_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!forced_done && cycle_count >= 400 && probe_ch.valid)
            begin
                forced_done = 1'b1;
                stall_left  = 96;
                steady_left = 0;
            end
            else if (stall_left == 0 && steady_left == 0)
            begin
                pick = $urandom_range(0, 999);
                if (pick < 3)
                    stall_left = $urandom_range(20, 80);
                else if (pick < 6)
                    steady_left = $urandom_range(100, 300);
            end
            if (stall_left > 0)
            begin
                drive_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (steady_left > 0)
            begin
                drive_ch.ready <= 1'b1;
                steady_left--;
            end
            else
            begin
                drive_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Offers one tick, after a random number of idle cycles unless the
    // sender is in its steady stretch, and returns at the edge that takes it.
    // The next tick is then driven in the same time step, so in the steady
    // stretch valid stays high across back-to-back transactions.
    task automatic drive_tick(input probe_arr_t p, input logic check,
                              input drive_result_t want);
        while (!sender_steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            probe_ch.valid <= 1'b0;
            @(posedge clk);
        end
        probe_ch.valid        <= 1'b1;
        probe_ch.probe_temp_0 <= p[0];
        probe_ch.probe_temp_1 <= p[1];
        probe_ch.probe_temp_2 <= p[2];
        probe_ch.probe_temp_3 <= p[3];
        fixed_check           <= check;
        fixed_result          <= want;
        do
            @(posedge clk);
        while (!probe_ch.ready);
    endtask

    // Stops offering ticks and waits until every result has been taken and
    // the pipeline has had time to drain.
    task automatic wait_idle();
        probe_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (ticks_in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Writes all four registers, with random junk above the width of each
    // narrower register so that the block is seen to ignore the spare bits.
    task automatic load_settings(input temp_t sp, input dev_t on_dev,
                                 input dev_t off_dev, input tick_t min_off);
        logic [31:0] pad;
        pad = $urandom;
        write_reg(REG_SET_TEMP, {pad[3:0], sp});
        write_reg(REG_ON_DEV, {pad[15:8], on_dev});
        write_reg(REG_OFF_DEV, {pad[23:16], off_dev});
        write_reg(REG_MIN_OFF, min_off);
        cfg_we <= 1'b0;
    endtask

    task automatic random_probes(output probe_arr_t p);
        logic [31:0] raw;
        for (int k = 0; k < INPUT_FIELDS; k++)
        begin
            raw  = $urandom;
            p[k] = raw[TEMP_W-1:0];
        end
    endtask

    // Mostly probes clustered around a centre near the set point, with a
    // spread chosen to land below, between or beyond the fan thresholds;
    // the rest are arbitrary bit patterns.
    task automatic plausible_probes(output probe_arr_t p);
        int centre;
        int spread;
        int pick;
        if (segment_left == 0)
        begin
            segment_left = $urandom_range(5, 60);
            trend        = trend_t'($urandom_range(0, 2));
        end
        segment_left--;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            random_probes(p);
        end
        else
        begin
            case (trend)
                TREND_WARM: centre = int'(set_point) + int'($urandom_range(1, 30));
                TREND_COOL: centre = int'(set_point) - int'($urandom_range(1, 30));
                default:    centre = int'(set_point) + int'($urandom_range(0, 8)) - 4;
            endcase
            case ($urandom_range(0, 2))
                0:       spread = int'(off_margin);
                1:       spread = int'(on_margin) + 4;
                default: spread = 300;
            endcase
            for (int k = 0; k < INPUT_FIELDS; k++)
                p[k] = clamp_temp(centre + int'($urandom_range(0, 2 * spread)) - spread);
        end
    endtask

    // Register settings for each random phase: both thresholds at zero, both
    // at their maximum, the on threshold below the off threshold, the
    // largest minimum off time, a high set point, fully random values and
    // the lowest set point in range.
    task automatic choose_settings(input int phase);
        int   sp;
        dev_t on_dev;
        sp     = int'($urandom_range(0, 2800)) - 800;
        on_dev = dev_t'($urandom_range(0, 40));
        case (phase)
            0: load_settings(temp_t'(sp), 8'd0, 8'd0, 16'd0);
            1: load_settings(temp_t'(sp), 8'd255, 8'd255, tick_t'($urandom_range(0, 40)));
            2: load_settings(temp_t'(sp), on_dev, on_dev + dev_t'($urandom_range(1, 60)),
                             tick_t'($urandom_range(0, 40)));
            SATURATION_PHASE:
               load_settings(temp_t'(-2048), dev_t'($urandom), dev_t'($urandom), 16'hFFFF);
            4: load_settings(temp_t'(2000), dev_t'($urandom), dev_t'($urandom),
                             tick_t'($urandom_range(0, 20)));
            5: load_settings(temp_t'($urandom), dev_t'($urandom), dev_t'($urandom),
                             tick_t'($urandom_range(0, 60)));
            default:
               load_settings(temp_t'(-800), dev_t'($urandom_range(0, 30)),
                             dev_t'($urandom_range(0, 30)), tick_t'($urandom_range(1, 10)));
        endcase
    endtask

    initial
    begin : stimulus
        step_t      row;
        probe_arr_t probes;
        int         phase;
        int         n;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_SET_TEMP;
        cfg_wdata             = '0;
        probe_ch.valid        = 1'b0;
        probe_ch.probe_temp_0 = '0;
        probe_ch.probe_temp_1 = '0;
        probe_ch.probe_temp_2 = '0;
        probe_ch.probe_temp_3 = '0;
        fixed_check           = 1'b0;
        fixed_result          = '0;
        sender_steady         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Register rows wait for the block to go idle first.
        for (n = 0; n < DIRECTED_STEPS; n++)
        begin
            row = directed_steps[n];
            if (row.is_write)
            begin
                wait_idle();
                write_reg(row.idx, row.wdata);
                cfg_we <= 1'b0;
            end
            else
            begin
                probes[0] = row.p0;
                probes[1] = row.p1;
                probes[2] = row.p2;
                probes[3] = row.p3;
                drive_tick(probes, row.check, {row.fan, row.comp, row.avg});
            end
        end

        // Random phases. In the phase at the largest minimum off time the set
        // point is the lowest value, so the off-time counter never clears and
        // keeps counting while the compressor stays off; the sender runs
        // without gaps there.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            choose_settings(phase);
            if (phase == SATURATION_PHASE)
            begin
                sender_steady = 1'b1;
                for (n = 0; n < SATURATION_TICKS; n++)
                begin
                    random_probes(probes);
                    drive_tick(probes, PRED, '0);
                end
                sender_steady = 1'b0;
            end
            else
            begin
                for (n = 0; n < PHASE_TICKS; n++)
                begin
                    plausible_probes(probes);
                    drive_tick(probes, PRED, '0);
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
